### hdl/herl_pkg.sv
// ----------------------------------------------------------------------------
// herl_pkg
// Types, register indexes, event codes and effect tables of the haptic event
// rate limiter.
// ----------------------------------------------------------------------------
package herl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int ELAPSED_W  = 32;
	localparam int DELTA_W    = 24;
	localparam int GAP_W      = 20;
	localparam int SCALE_W    = 16;
	localparam int EV_W       = 4;
	localparam int DUR_W      = 17;
	localparam int Q_W        = 16;
	localparam int AMP_W      = 22;
	localparam int CAPS_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USER_STRENGTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_US      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQUENT_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_CAPS     = 3'd5;

	localparam int CAP_VIBRATOR    = 0;
	localparam int CAP_AMPLITUDE   = 1;
	localparam int CAP_COMPOSITION = 2;
	localparam int CAP_ENVELOPE    = 3;

	localparam logic [SCALE_W-1:0]   SCALE_UNITY     = 16'd16384;
	localparam logic [CAPS_W-1:0]    CAPS_RESET      = 4'd1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_RESET   = 32'd999000000;
	localparam logic [Q_W-1:0]       Q_FULL          = 16'hFFFF;

	localparam logic [EV_W-1:0] EV_UI_CONFIRM      = 4'd0;
	localparam logic [EV_W-1:0] EV_UI_ERROR        = 4'd1;
	localparam logic [EV_W-1:0] EV_FIRE_LIGHT      = 4'd2;
	localparam logic [EV_W-1:0] EV_FIRE_HEAVY      = 4'd3;
	localparam logic [EV_W-1:0] EV_RELOAD_INSERT   = 4'd4;
	localparam logic [EV_W-1:0] EV_RELOAD_COMPLETE = 4'd5;
	localparam logic [EV_W-1:0] EV_PLAYER_HIT      = 4'd6;
	localparam logic [EV_W-1:0] EV_GRAB            = 4'd7;
	localparam logic [EV_W-1:0] EV_EXPLOSION_NEAR  = 4'd8;
	localparam logic [EV_W-1:0] EV_SLIDE           = 4'd9;
	localparam logic [EV_W-1:0] EV_MANTLE          = 4'd10;
	localparam logic [EV_W-1:0] EV_HEARTBEAT       = 4'd11;
	localparam logic [EV_W-1:0] EV_STINGER         = 4'd12;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               start;
		logic [AMP_W-1:0]   a;
		logic [SCALE_W-1:0] b;
	} mul_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

	function automatic logic is_frequent(input logic [EV_W-1:0] ev);
		return (ev == EV_FIRE_LIGHT) || (ev == EV_FIRE_HEAVY) ||
			(ev == EV_RELOAD_INSERT) || (ev == EV_HEARTBEAT);
	endfunction

	function automatic logic [Q_W-1:0] amp_lut(input logic [EV_W-1:0] ev);
		logic [Q_W-1:0] v;
		unique case (ev)
			EV_UI_CONFIRM:      v = 16'd11796;
			EV_UI_ERROR:        v = 16'd18350;
			EV_FIRE_LIGHT:      v = 16'd15729;
			EV_FIRE_HEAVY:      v = 16'd30147;
			EV_RELOAD_INSERT:   v = 16'd10486;
			EV_RELOAD_COMPLETE: v = 16'd16384;
			EV_PLAYER_HIT:      v = 16'd38011;
			EV_GRAB:            v = 16'd47186;
			EV_EXPLOSION_NEAR:  v = 16'd55706;
			EV_SLIDE:           v = 16'd20972;
			EV_MANTLE:          v = 16'd14418;
			EV_HEARTBEAT:       v = 16'd19661;
			EV_STINGER:         v = 16'd34079;
			default:            v = 16'd13107;
		endcase
		return v;
	endfunction

	function automatic logic [DUR_W-1:0] dur_lut(input logic [EV_W-1:0] ev);
		logic [DUR_W-1:0] v;
		unique case (ev)
			EV_UI_CONFIRM:      v = 17'd12000;
			EV_UI_ERROR:        v = 17'd20000;
			EV_FIRE_LIGHT:      v = 17'd12000;
			EV_FIRE_HEAVY:      v = 17'd20000;
			EV_RELOAD_INSERT:   v = 17'd10000;
			EV_RELOAD_COMPLETE: v = 17'd16000;
			EV_PLAYER_HIT:      v = 17'd30000;
			EV_GRAB:            v = 17'd60000;
			EV_EXPLOSION_NEAR:  v = 17'd75000;
			EV_SLIDE:           v = 17'd22000;
			EV_MANTLE:          v = 17'd16000;
			EV_HEARTBEAT:       v = 17'd30000;
			EV_STINGER:         v = 17'd40000;
			default:            v = 17'd16000;
		endcase
		return v;
	endfunction

	function automatic logic [Q_W-1:0] sharp_lut(input logic [EV_W-1:0] ev);
		logic [Q_W-1:0] v;
		unique case (ev)
			EV_UI_CONFIRM:      v = 16'd58982;
			EV_UI_ERROR:        v = 16'd47186;
			EV_FIRE_LIGHT:      v = 16'd53740;
			EV_FIRE_HEAVY:      v = 16'd45875;
			EV_RELOAD_INSERT:   v = 16'd57672;
			EV_RELOAD_COMPLETE: v = 16'd52429;
			EV_PLAYER_HIT:      v = 16'd36045;
			EV_GRAB:            v = 16'd23593;
			EV_EXPLOSION_NEAR:  v = 16'd13107;
			EV_SLIDE:           v = 16'd31457;
			EV_MANTLE:          v = 16'd44564;
			EV_HEARTBEAT:       v = 16'd18350;
			EV_STINGER:         v = 16'd34079;
			default:            v = 16'd39322;
		endcase
		return v;
	endfunction

endpackage

### hdl/herl_if.sv
// ----------------------------------------------------------------------------
// herl request and response channels
// Valid/ready channels carrying a haptic request and its playback decision.
// ----------------------------------------------------------------------------
interface herl_req_if import herl_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EV_W-1:0]    event_code;
	logic [DELTA_W-1:0] delta_us;

	modport source (output valid, event_code, delta_us, input ready);
	modport sink (input valid, event_code, delta_us, output ready);
endinterface

interface herl_rsp_if import herl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [EV_W-1:0]  event_echo;
	logic             play;
	logic [Q_W-1:0]   amplitude;
	logic [DUR_W-1:0] duration_us;
	logic [Q_W-1:0]   sharpness;
	logic             prefer_composition;
	logic             prefer_envelope;

	modport source (output valid, event_echo, play, amplitude, duration_us, sharpness,
		prefer_composition, prefer_envelope, input ready);
	modport sink (input valid, event_echo, play, amplitude, duration_us, sharpness,
		prefer_composition, prefer_envelope, output ready);
endinterface

### hdl/herl_serial_mul.sv
// ----------------------------------------------------------------------------
// herl_serial_mul
// Bit-serial shift-add multiplier, one scale bit per cycle, MSB first.
// Result is a times the Q2.14 scale b, truncated to the width of a.
// ----------------------------------------------------------------------------
module herl_serial_mul import herl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  mul_ctl_t         ctl,
	output mul_sts_t         sts,
	output logic [AMP_W-1:0] p
);

	localparam int ACC_W = AMP_W + SCALE_W;
	localparam int CNT_W = $clog2(SCALE_W + 1);

	logic [ACC_W-1:0]   acc_q;
	logic [AMP_W-1:0]   a_q;
	logic [SCALE_W-1:0] b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= CNT_W'(SCALE_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			a_q   <= ctl.a;
			b_q   <= ctl.b;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[ACC_W-2:0], 1'b0} + (b_q[SCALE_W-1] ? ACC_W'(a_q) : '0);
			b_q   <= {b_q[SCALE_W-2:0], 1'b0};
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign p        = acc_q[AMP_W+13:14];

	a_done_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0)) else $error("multiplier done with bits left");

endmodule

### hdl/herl_gap_timer.sv
// ----------------------------------------------------------------------------
// herl_gap_timer
// Saturating elapsed-time register and minimum-gap check.
// ----------------------------------------------------------------------------
module herl_gap_timer import herl_pkg::*; #(
	parameter int MAX_DELTA_US    = 1000000,
	parameter int FREQUENT_GAP_US = 30000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [DELTA_W-1:0] delta_us,
	input  logic               clear,
	input  logic               freq,
	input  logic [GAP_W-1:0]   min_gap_us,
	output logic               gap_ok
);

	localparam logic [DELTA_W-1:0] MAX_D  = DELTA_W'(MAX_DELTA_US);
	localparam logic [GAP_W-1:0]   FREQ_G = GAP_W'(FREQUENT_GAP_US);

	logic [ELAPSED_W-1:0] elapsed_q;
	logic [DELTA_W-1:0]   delta_c;
	logic [ELAPSED_W:0]   sum;
	logic [GAP_W-1:0]     gap;

	assign delta_c = (delta_us > MAX_D) ? MAX_D : delta_us;
	assign sum     = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(delta_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= ELAPSED_RESET;
		end else if (accept) begin
			elapsed_q <= sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
		end else if (clear) begin
			elapsed_q <= '0;
		end
	end

	assign gap    = (freq && (min_gap_us < FREQ_G)) ? FREQ_G : min_gap_us;
	assign gap_ok = (elapsed_q >= ELAPSED_W'(gap));

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(clear && !accept) |=> (elapsed_q == '0)) else $error("elapsed time not cleared");

endmodule

### hdl/haptic_event_rate_limiter.sv
// ----------------------------------------------------------------------------
// haptic_event_rate_limiter
// Drops or plays haptic requests and computes the scaled effect parameters.
// ----------------------------------------------------------------------------
// One request is taken at a time and yields one response. A dropped request
// passes from acceptance through the check and output states. A played one
// runs the amplitude through the serial multiplier once per applicable gain
// (user strength always, frequent and heartbeat gains as the event requires),
// an issue and a multiply state a pass, before the output state. The response
// sits in an output register, so the next request is accepted while it waits.
// ----------------------------------------------------------------------------
module haptic_event_rate_limiter import herl_pkg::*; #(
	parameter int MAX_DELTA_US    = 1000000,
	parameter int FREQUENT_GAP_US = 30000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	herl_req_if.sink              req,
	herl_rsp_if.source            rsp
);

	state_t state_q, state_d;

	logic               enable_q;
	logic [SCALE_W-1:0] user_strength_q;
	logic [GAP_W-1:0]   min_gap_us_q;
	logic [SCALE_W-1:0] frequent_scale_q;
	logic [SCALE_W-1:0] heartbeat_scale_q;
	logic [CAPS_W-1:0]  device_caps_q;

	logic [EV_W-1:0]  ev_q;
	logic             play_q;
	logic [AMP_W-1:0] s_q;
	logic [2:0]       rem_q;

	logic             rsp_valid_q;
	logic [EV_W-1:0]  echo_q;
	logic             play_out_q;
	logic [Q_W-1:0]   amp_out_q;
	logic [DUR_W-1:0] dur_out_q;
	logic [Q_W-1:0]   sharp_out_q;
	logic             comp_out_q;
	logic             env_out_q;

	logic             accept;
	logic             freq;
	logic             gap_ok;
	logic             play_now;
	logic             tmr_clear;
	logic             out_free;
	logic             out_load;
	logic             req_ready;
	mul_ctl_t         mul_ctl;
	mul_sts_t         mul_sts;
	logic [AMP_W-1:0] mul_p;
	logic [Q_W-1:0]   amp_sat;
	logic [Q_W-1:0]   amp_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q          <= 1'b1;
			user_strength_q   <= SCALE_UNITY;
			min_gap_us_q      <= '0;
			frequent_scale_q  <= SCALE_UNITY;
			heartbeat_scale_q <= SCALE_UNITY;
			device_caps_q     <= CAPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:          enable_q          <= cfg_wdata[0];
				REG_USER_STRENGTH:   user_strength_q   <= cfg_wdata[SCALE_W-1:0];
				REG_MIN_GAP_US:      min_gap_us_q      <= cfg_wdata[GAP_W-1:0];
				REG_FREQUENT_SCALE:  frequent_scale_q  <= cfg_wdata[SCALE_W-1:0];
				REG_HEARTBEAT_SCALE: heartbeat_scale_q <= cfg_wdata[SCALE_W-1:0];
				REG_DEVICE_CAPS:     device_caps_q     <= cfg_wdata[CAPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept   = req.valid && req_ready;
	assign freq     = is_frequent(ev_q);
	assign play_now = enable_q && device_caps_q[CAP_VIBRATOR] &&
		(user_strength_q != '0) && gap_ok;
	assign out_free = !rsp_valid_q || rsp.ready;

	herl_gap_timer #(
		.MAX_DELTA_US    (MAX_DELTA_US),
		.FREQUENT_GAP_US (FREQUENT_GAP_US)
	) u_timer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.delta_us   (req.delta_us),
		.clear      (tmr_clear),
		.freq       (freq),
		.min_gap_us (min_gap_us_q),
		.gap_ok     (gap_ok)
	);

	herl_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.sts    (mul_sts),
		.p      (mul_p)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_CHECK;
			ST_CHECK: state_d = play_now ? ST_ISSUE : ST_OUT;
			ST_ISSUE: state_d = ST_MUL;
			ST_MUL: begin
				if (mul_sts.done)
					state_d = (rem_q != '0) ? ST_ISSUE : ST_OUT;
			end
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = (state_q == ST_IDLE);
		tmr_clear     = (state_q == ST_CHECK) && play_now;
		out_load      = (state_q == ST_OUT) && out_free;
		mul_ctl.start = (state_q == ST_ISSUE);
		mul_ctl.a     = s_q;
		priority if (rem_q[0])
			mul_ctl.b = frequent_scale_q;
		else if (rem_q[1])
			mul_ctl.b = heartbeat_scale_q;
		else
			mul_ctl.b = user_strength_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			ev_q <= req.event_code;
		if (state_q == ST_CHECK) begin
			play_q <= play_now;
			s_q    <= AMP_W'(amp_lut(ev_q));
			rem_q  <= {1'b1, ev_q == EV_HEARTBEAT, freq};
		end
		if (state_q == ST_ISSUE)
			rem_q <= rem_q & (rem_q - 3'd1);
		if ((state_q == ST_MUL) && mul_sts.done)
			s_q <= mul_p;
	end

	assign amp_sat = (s_q > AMP_W'(Q_FULL)) ? Q_FULL : s_q[Q_W-1:0];
	assign amp_fin = device_caps_q[CAP_AMPLITUDE] ? amp_sat :
		((s_q != '0) ? Q_FULL : '0);

	always_ff @(posedge clk) begin
		if (out_load) begin
			echo_q     <= ev_q;
			play_out_q <= play_q;
			if (play_q) begin
				amp_out_q   <= amp_fin;
				dur_out_q   <= dur_lut(ev_q);
				sharp_out_q <= sharp_lut(ev_q);
				comp_out_q  <= device_caps_q[CAP_COMPOSITION] && ((ev_q == EV_GRAB) ||
					(ev_q == EV_EXPLOSION_NEAR) || (ev_q == EV_STINGER));
				env_out_q   <= device_caps_q[CAP_ENVELOPE] &&
					((ev_q == EV_GRAB) || (ev_q == EV_EXPLOSION_NEAR));
			end else begin
				amp_out_q   <= '0;
				dur_out_q   <= '0;
				sharp_out_q <= '0;
				comp_out_q  <= 1'b0;
				env_out_q   <= 1'b0;
			end
		end
	end

	assign req.ready              = req_ready;
	assign rsp.valid              = rsp_valid_q;
	assign rsp.event_echo         = echo_q;
	assign rsp.play               = play_out_q;
	assign rsp.amplitude          = amp_out_q;
	assign rsp.duration_us        = dur_out_q;
	assign rsp.sharpness          = sharp_out_q;
	assign rsp.prefer_composition = comp_out_q;
	assign rsp.prefer_envelope    = env_out_q;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !play_out_q) |-> ((amp_out_q == '0) && (dur_out_q == '0) &&
		(sharp_out_q == '0) && !comp_out_q && !env_out_q))
		else $error("dropped request carries effect data");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> (state_q == ST_MUL)) else $error("multiplier result unclaimed");

	a_mul_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		mul_ctl.start |-> !mul_sts.busy) else $error("multiplier restarted while busy");

endmodule
